>>> design/dual_pol_phase_and_sum_beamformer_core_defines.svh
// ----------------------------------------------------------------------------
// Beamformer assertion macros
// Concurrent assertion forms used by the beamformer controller.
// ----------------------------------------------------------------------------
`ifndef DUAL_POL_PHASE_AND_SUM_BEAMFORMER_CORE_DEFINES_SVH
`define DUAL_POL_PHASE_AND_SUM_BEAMFORMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPBF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/dpbf_pkg.sv
// ----------------------------------------------------------------------------
// Beamformer package
// Result layout constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dpbf_pkg;

   localparam int RSP_FIELD_W = 32;
   localparam int NUM_LANES   = 4;   // beam0 re/im, beam1 re/im
   localparam int NUM_BEAMS   = 2;
   localparam int RSP_DATA_W  = NUM_LANES * RSP_FIELD_W;
   localparam int REQ_USER_W  = NUM_BEAMS;

   localparam logic [RSP_FIELD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [RSP_FIELD_W-1:0] SAT_NEG = 32'h8000_0000;

   // controller -> datapath
   typedef struct packed {
      logic take;      // input transfer this cycle
      logic load;      // capture magnitudes into divider, clear accumulators
      logic round;     // add half divisor for round to nearest
      logic step;      // one restoring division step
      logic publish;   // load result register
   } dpbf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pipe_busy; // MAC pipeline still holds items
   } dpbf_sts_type;

endpackage

>>> design/dpbf_ctrl.sv
// ----------------------------------------------------------------------------
// Beamformer controller
// Handshake and sequencing: accumulate, drain, round, divide, publish.
// ----------------------------------------------------------------------------
`include "dual_pol_phase_and_sum_beamformer_core_defines.svh"

module dpbf_ctrl #(
   parameter int DIV_STEPS = 42
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dpbf_pkg::dpbf_cmd_type cmd,
   input  dpbf_pkg::dpbf_sts_type sts
);
   import dpbf_pkg::*;

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_ROUND,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              req_tready_ff, req_tready_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              take;
   logic              slot_free;

   always_comb begin
      take          = req_tvalid && req_tready_ff;
      slot_free     = !rsp_tvalid_ff || rsp_tready;
      state_in      = state_ff;
      step_in       = step_ff;
      req_tready_in = req_tready_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      cmd.take      = take;
      case (state_ff)
         ST_ACCUM: begin
            req_tready_in = !(take && req_tlast);
            if (take && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               cmd.load = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            step_in   = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.publish   = 1'b1;
               rsp_tvalid_in = 1'b1;
               req_tready_in = 1'b1;
               state_in      = ST_ACCUM;
            end
         end
         default: begin
            state_in      = ST_ACCUM;
            req_tready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACCUM;
         step_ff       <= '0;
         req_tready_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         req_tready_ff <= req_tready_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   `DPBF_ASSERT_NEXT(a_last_closes_input, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input open after last antenna")
   `DPBF_ASSERT_IMPLY(a_load_after_drain, clock, reset, cmd.load, !sts.pipe_busy, "divider loaded with MAC pipeline busy")
   `DPBF_ASSERT_IMPLY(a_publish_slot_free, clock, reset, cmd.publish, !rsp_tvalid || rsp_tready, "result overwritten before transfer")
   `DPBF_ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp_tvalid && req_tready, "published result not presented")

endmodule

>>> design/dpbf_datapath.sv
// ----------------------------------------------------------------------------
// Beamformer datapath
// Complex MAC pipeline, beam accumulators, four-lane restoring divider.
// ----------------------------------------------------------------------------
module dpbf_datapath #(
   parameter int SAMPLE_BITS  = 16,
   parameter int WEIGHT_BITS  = 16,
   parameter int MAX_ANTENNAS = 256,
   parameter int CNT_W        = 9,
   parameter int ACC_W        = 41,
   parameter int DVD_W        = 42
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   input  logic signed [SAMPLE_BITS-1:0]     sample_re,
   input  logic signed [SAMPLE_BITS-1:0]     sample_im,
   input  logic signed [WEIGHT_BITS-1:0]     weight_re,
   input  logic signed [WEIGHT_BITS-1:0]     weight_im,
   input  logic [dpbf_pkg::NUM_BEAMS-1:0]    use_in_beam,
   input  dpbf_pkg::dpbf_cmd_type            cmd,
   output dpbf_pkg::dpbf_sts_type            sts,
   output logic [dpbf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import dpbf_pkg::*;

   localparam int MUL_W = SAMPLE_BITS + WEIGHT_BITS;
   localparam int Q_W   = (DVD_W > RSP_FIELD_W + 1) ? DVD_W : RSP_FIELD_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ANTENNAS);

   logic                          real_input_ff;
   logic signed [SAMPLE_BITS-1:0] sim_eff;

   // stage 1: partial products
   logic                   s1_vld_ff;
   logic [NUM_BEAMS-1:0]   s1_use_ff;
   logic signed [MUL_W-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [MUL_W-1:0] prr_in, pii_in, pri_in, pir_in;

   // stage 2: complex product
   logic                   s2_vld_ff;
   logic [NUM_BEAMS-1:0]   s2_use_ff;
   logic signed [ACC_W-1:0] pre_ff, pim_ff, pre_in, pim_in;

   // stage 3: accumulators
   logic signed [ACC_W-1:0] sum_ff [NUM_LANES];
   logic signed [ACC_W-1:0] sum_in [NUM_LANES];
   logic [CNT_W-1:0]        cnt_ff [NUM_BEAMS];
   logic [CNT_W-1:0]        cnt_in [NUM_BEAMS];
   logic [NUM_BEAMS-1:0]    add_en;

   // divider lanes
   logic                    neg_ff [NUM_LANES];
   logic [CNT_W-1:0]        div_ff [NUM_LANES];
   logic [CNT_W-1:0]        rem_ff [NUM_LANES];
   logic [CNT_W-1:0]        rem_in [NUM_LANES];
   logic [DVD_W-1:0]        dvd_ff [NUM_LANES];
   logic [DVD_W-1:0]        dvd_in [NUM_LANES];
   logic [DVD_W-1:0]        ext_w  [NUM_LANES];
   logic [DVD_W-1:0]        mag_w  [NUM_LANES];
   logic [CNT_W:0]          trial_w[NUM_LANES];
   logic [CNT_W:0]          diff_w [NUM_LANES];
   logic                    ge_w   [NUM_LANES];
   logic [Q_W-1:0]          qx_w   [NUM_LANES];
   logic [RSP_FIELD_W-1:0]  res_w  [NUM_LANES];
   logic [RSP_FIELD_W-1:0]  rsp_ff [NUM_LANES];

   always_comb begin
      sim_eff = real_input_ff ? '0 : sample_im;
      prr_in  = weight_re * sample_re;
      pii_in  = weight_im * sim_eff;
      pri_in  = weight_re * sim_eff;
      pir_in  = weight_im * sample_re;
      pre_in  = ACC_W'(prr_ff) - ACC_W'(pii_ff);
      pim_in  = ACC_W'(pri_ff) + ACC_W'(pir_ff);
   end

   always_comb begin
      for (int b = 0; b < NUM_BEAMS; b++) begin
         add_en[b] = s2_vld_ff && s2_use_ff[b] && (cnt_ff[b] < CNT_MAX);
         if (cmd.load) begin
            cnt_in[b] = '0;
         end else if (add_en[b]) begin
            cnt_in[b] = cnt_ff[b] + 1'b1;
         end else begin
            cnt_in[b] = cnt_ff[b];
         end
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         if (cmd.load) begin
            sum_in[l] = '0;
         end else if (add_en[l >> 1]) begin
            sum_in[l] = sum_ff[l] + (((l & 1) != 0) ? pim_ff : pre_ff);
         end else begin
            sum_in[l] = sum_ff[l];
         end
      end
   end

   // restoring division of |sum| + count/2 by count, quotient shifts into dvd
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         ext_w[l]   = DVD_W'(sum_ff[l]);
         mag_w[l]   = ext_w[l][DVD_W-1] ? ('0 - ext_w[l]) : ext_w[l];
         trial_w[l] = {rem_ff[l], dvd_ff[l][DVD_W-1]};
         diff_w[l]  = trial_w[l] - {1'b0, div_ff[l]};
         ge_w[l]    = (trial_w[l] >= {1'b0, div_ff[l]});
         if (cmd.load) begin
            dvd_in[l] = mag_w[l];
            rem_in[l] = '0;
         end else if (cmd.round) begin
            dvd_in[l] = dvd_ff[l] + DVD_W'(div_ff[l] >> 1);
            rem_in[l] = '0;
         end else if (cmd.step) begin
            dvd_in[l] = {dvd_ff[l][DVD_W-2:0], ge_w[l]};
            rem_in[l] = ge_w[l] ? diff_w[l][CNT_W-1:0] : trial_w[l][CNT_W-1:0];
         end else begin
            dvd_in[l] = dvd_ff[l];
            rem_in[l] = rem_ff[l];
         end
         qx_w[l] = Q_W'(dvd_ff[l]);
         if (div_ff[l] == '0) begin
            res_w[l] = '0;
         end else if (neg_ff[l]) begin
            res_w[l] = (qx_w[l] > Q_W'(SAT_NEG)) ? SAT_NEG : ('0 - qx_w[l][RSP_FIELD_W-1:0]);
         end else begin
            res_w[l] = (qx_w[l] > Q_W'(SAT_POS)) ? SAT_POS : qx_w[l][RSP_FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_input_ff <= 1'b0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         for (int b = 0; b < NUM_BEAMS; b++) begin
            cnt_ff[b] <= '0;
         end
         for (int l = 0; l < NUM_LANES; l++) begin
            sum_ff[l] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            real_input_ff <= csr_wr_data;
         end
         s1_vld_ff <= cmd.take;
         s2_vld_ff <= s1_vld_ff;
         for (int b = 0; b < NUM_BEAMS; b++) begin
            cnt_ff[b] <= cnt_in[b];
         end
         for (int l = 0; l < NUM_LANES; l++) begin
            sum_ff[l] <= sum_in[l];
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         s1_use_ff <= use_in_beam;
         prr_ff    <= prr_in;
         pii_ff    <= pii_in;
         pri_ff    <= pri_in;
         pir_ff    <= pir_in;
      end
      s2_use_ff <= s1_use_ff;
      pre_ff    <= pre_in;
      pim_ff    <= pim_in;
      for (int l = 0; l < NUM_LANES; l++) begin
         dvd_ff[l] <= dvd_in[l];
         rem_ff[l] <= rem_in[l];
         if (cmd.load) begin
            neg_ff[l] <= sum_ff[l][ACC_W-1];
            div_ff[l] <= cnt_ff[l >> 1];
         end
         if (cmd.publish) begin
            rsp_ff[l] <= res_w[l];
         end
      end
   end

   always_comb begin
      sts.pipe_busy = s1_vld_ff || s2_vld_ff;
      for (int l = 0; l < NUM_LANES; l++) begin
         rsp_tdata[l*RSP_FIELD_W +: RSP_FIELD_W] = rsp_ff[l];
      end
   end

endmodule

>>> design/dual_pol_phase_and_sum_beamformer_core.sv
// ----------------------------------------------------------------------------
// Dual-polarization phase-and-sum beamformer core
// Weighted complex sum of antenna samples into two beams, averaged per beam.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one antenna per transfer: sample and weight in tdata,
//    beam membership flags in tuser, tlast on the final antenna of a sum.
//  - csr_wr_en/csr_wr_data set real_input; write it only while idle.
//  - rsp_* carries one result per sum: both beams, each averaged over its
//    contributor count, rounded to nearest, saturated to 32 bits.
//  - Non-last antennas are taken one per cycle through a 3-stage MAC pipe.
//  - After the tlast transfer, req_tready stays low through MAC drain,
//    load, round, DVD_W steps of the 4-lane restoring divider and
//    publish. The result shows on rsp_tvalid at the edge req_tready
//    returns high.
//  - If rsp_tready is low, the held result does not block new antennas;
//    only the next publish waits until the result register is free.
//  - Synchronous reset clears accumulators, counts, real_input and both
//    valid flags; req_tready is registered and rises in the cycle after reset is released.
// ----------------------------------------------------------------------------
module dual_pol_phase_and_sum_beamformer_core #(
   parameter int MAX_ANTENNAS = 256,
   parameter int SAMPLE_BITS  = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic                                   csr_wr_data,   // real_input
   // antenna stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sample_re, sample_im, weight_re, weight_im (low to high), zero pad
   input  logic [((2*SAMPLE_BITS+2*WEIGHT_BITS+7)/8)*8-1:0] req_tdata,
   // use_in_beam0, use_in_beam1 (low to high)
   input  logic [dpbf_pkg::REQ_USER_W-1:0]        req_tuser,
   input  logic                                   req_tlast,     // last_antenna
   // beam results
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // beam0_re, beam0_im, beam1_re, beam1_im (low to high)
   output logic [dpbf_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import dpbf_pkg::*;

   // product, count and accumulator widths; accumulator width capped at 64 bits
   localparam int MUL_W    = SAMPLE_BITS + WEIGHT_BITS;
   localparam int CNT_W    = $clog2(MAX_ANTENNAS + 1);
   localparam int ACC_FULL = MUL_W + 1 + CNT_W;
   localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
   // dividend holds |sum| plus half the count
   localparam int DVD_W    = ACC_W + 1;

   localparam int SIM_LO = SAMPLE_BITS;
   localparam int WRE_LO = 2 * SAMPLE_BITS;
   localparam int WIM_LO = 2 * SAMPLE_BITS + WEIGHT_BITS;

   logic signed [SAMPLE_BITS-1:0] sample_re;
   logic signed [SAMPLE_BITS-1:0] sample_im;
   logic signed [WEIGHT_BITS-1:0] weight_re;
   logic signed [WEIGHT_BITS-1:0] weight_im;
   dpbf_cmd_type                  cmd;
   dpbf_sts_type                  sts;

   assign sample_re = req_tdata[SAMPLE_BITS-1:0];
   assign sample_im = req_tdata[SIM_LO +: SAMPLE_BITS];
   assign weight_re = req_tdata[WRE_LO +: WEIGHT_BITS];
   assign weight_im = req_tdata[WIM_LO +: WEIGHT_BITS];

   dpbf_ctrl #(
      .DIV_STEPS (DVD_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   dpbf_datapath #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .WEIGHT_BITS  (WEIGHT_BITS),
      .MAX_ANTENNAS (MAX_ANTENNAS),
      .CNT_W        (CNT_W),
      .ACC_W        (ACC_W),
      .DVD_W        (DVD_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .sample_re   (sample_re),
      .sample_im   (sample_im),
      .weight_re   (weight_re),
      .weight_im   (weight_im),
      .use_in_beam (req_tuser),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
